// ===== hw/rtl/clwsa_pkg.sv =====
// Package for the current loop wind speed averager.
// Holds widths, reset values, register indexes, arithmetic constants and divider structs.
// No dependencies.
package clwsa_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 11;
    localparam int SPAN_W     = 7;
    localparam int OFFSET_W   = 10;
    localparam int GAP_W      = 16;

    localparam int AVG_DEPTH  = 3;
    localparam int PTR_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W     = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W      = SPEED_W + $clog2(AVG_DEPTH + 1);

    localparam int FRAC_W     = 7;
    localparam int NUMER_W    = SAMPLE_W + FRAC_W;
    localparam int LIN_W      = 14;
    localparam int RECIP_W    = 16;
    localparam int PROD_W     = LIN_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;

    localparam int DIV_W      = NUMER_W;
    localparam int DVS_W      = SAMPLE_W;
    localparam int CNT_W      = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] FLOOR_RST  = 12'd819;
    localparam logic [SPAN_W-1:0]   SPAN_RST   = 7'd45;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 10'd80;
    localparam logic [GAP_W-1:0]    GAP_RST    = 16'd599;
    localparam logic [SAMPLE_W-1:0] MIN_RST    = 12'd819;
    localparam logic [SAMPLE_W-1:0] MAX_RST    = 12'd4095;

    localparam logic [NUMER_W-1:0]  PCT_SCALE  = 19'd100;
    localparam logic [RECIP_W-1:0]  RECIP_TEN  = 16'd52429;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 8'd3;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/clwsa_if.sv =====
// Channel interfaces for the current loop wind speed averager.
// Sample request, speed result and configuration write channels; depends on clwsa_pkg.
interface clwsa_in_if
    import clwsa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;
    logic [TIME_W-1:0]   now_seconds;

    modport source (output valid, output adc_sample, output now_seconds, input ready);
    modport sink   (input valid, input adc_sample, input now_seconds, output ready);
endinterface

interface clwsa_out_if
    import clwsa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SPEED_W-1:0]  wind_speed_tenths;
    logic [SAMPLE_W-1:0] sample_min;
    logic [SAMPLE_W-1:0] sample_max;
    logic                log_now;

    modport source (output valid, output wind_speed_tenths, output sample_min,
                    output sample_max, output log_now, input ready);
    modport sink   (input valid, input wind_speed_tenths, input sample_min,
                    input sample_max, input log_now, output ready);
endinterface

interface clwsa_cfg_if
    import clwsa_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/clwsa_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on clwsa_pkg for widths and the request/response structs.
module clwsa_div
    import clwsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/current_loop_wind_speed_averager_top.sv =====
// A sample below the floor skips the fraction divide and goes straight to the ring store.
// Both divides run on the one shared divider; the ring sum adds the filled entries one at a time.
// One request at a time; ready returns once the result loads.
// Reset (rst_n, async, active low) restores register defaults, min/max and clears ring fill.
// Depends on clwsa_pkg, clwsa_if and clwsa_div.
module current_loop_wind_speed_averager_top
    import clwsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    clwsa_in_if.sink     sample_in,
    clwsa_out_if.source  speed_out,
    clwsa_cfg_if.sink    cfg
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCALE     = 4'd1;
    localparam logic [3:0] S_FRAC_GO   = 4'd2;
    localparam logic [3:0] S_FRAC_WAIT = 4'd3;
    localparam logic [3:0] S_MAC       = 4'd4;
    localparam logic [3:0] S_TEN       = 4'd5;
    localparam logic [3:0] S_STORE     = 4'd6;
    localparam logic [3:0] S_SUM       = 4'd7;
    localparam logic [3:0] S_AVG_GO    = 4'd8;
    localparam logic [3:0] S_AVG_WAIT  = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [SAMPLE_W-1:0] floor_reg, floor_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [GAP_W-1:0]    gap_reg, gap_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [SAMPLE_W-1:0] s_reg, s_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [NUMER_W-1:0]  numer_reg, numer_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [LIN_W-1:0]    lin_reg, lin_next;
    logic [SPEED_W-1:0]  inst_reg, inst_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SPEED_W-1:0]  avg_reg, avg_next;
    logic [SPEED_W-1:0]  last_speed_reg, last_speed_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic                out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]  out_speed_reg, out_speed_next;
    logic [SAMPLE_W-1:0] out_min_reg, out_min_next;
    logic [SAMPLE_W-1:0] out_max_reg, out_max_next;
    logic                out_log_reg, out_log_next;

    logic [SPEED_W-1:0]  speed_ring [AVG_DEPTH];
    logic                ring_we;

    logic [SAMPLE_W-1:0] range_w;
    logic [PROD_W-1:0]   prod_w;
    logic [TIME_W-1:0]   elapsed_w;
    logic                log_w;
    logic                in_take;
    logic                cfg_take;

    div_req_t div_req;
    div_rsp_t div_rsp;

    clwsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample_in.ready = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign in_take         = sample_in.valid && sample_in.ready;
    assign cfg_take        = cfg.valid && cfg.ready;

    assign range_w   = max_reg - min_reg;
    assign prod_w    = PROD_W'(lin_reg) * PROD_W'(RECIP_TEN);
    assign elapsed_w = now_reg - last_time_reg;
    assign log_w     = (avg_reg != last_speed_reg) && (elapsed_w > TIME_W'(gap_reg));

    always_comb
    begin
        div_req.start    = (state_reg == S_FRAC_GO) || (state_reg == S_AVG_GO);
        div_req.dividend = (state_reg == S_AVG_GO) ? DIV_W'(sum_reg) : numer_reg;
        div_req.divisor  = (state_reg == S_AVG_GO) ? DVS_W'(fill_reg) : range_w;
    end

    always_comb
    begin
        state_next      = state_reg;
        floor_next      = floor_reg;
        span_next       = span_reg;
        offset_next     = offset_reg;
        gap_next        = gap_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        s_next          = s_reg;
        now_next        = now_reg;
        numer_next      = numer_reg;
        frac_next       = frac_reg;
        lin_next        = lin_reg;
        inst_next       = inst_reg;
        ptr_next        = ptr_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        avg_next        = avg_reg;
        last_speed_next = last_speed_reg;
        last_time_next  = last_time_reg;
        out_valid_next  = out_valid_reg && !speed_out.ready;
        out_speed_next  = out_speed_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_log_next    = out_log_reg;
        ring_we         = 1'b0;

        if (cfg_take)
        begin
            case (cfg.index)
                CFG_FLOOR:  floor_next  = cfg.data[SAMPLE_W-1:0];
                CFG_SPAN:   span_next   = cfg.data[SPAN_W-1:0];
                CFG_OFFSET: offset_next = cfg.data[OFFSET_W-1:0];
                CFG_GAP:    gap_next    = cfg.data[GAP_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    s_next   = sample_in.adc_sample;
                    now_next = sample_in.now_seconds;
                    if (sample_in.adc_sample > max_reg)
                        max_next = sample_in.adc_sample;
                    if (sample_in.adc_sample < min_reg)
                        min_next = sample_in.adc_sample;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                numer_next = NUMER_W'(s_reg - min_reg) * PCT_SCALE;
                frac_next  = '0;
                if (s_reg < floor_reg)
                begin
                    inst_next  = '0;
                    state_next = S_STORE;
                end
                else if (range_w == '0)
                    state_next = S_MAC;
                else
                    state_next = S_FRAC_GO;
            end
            S_FRAC_GO:
                state_next = S_FRAC_WAIT;
            S_FRAC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    frac_next  = div_rsp.quotient[FRAC_W-1:0];
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                lin_next   = LIN_W'(frac_reg) * LIN_W'(span_reg) + LIN_W'(offset_reg);
                state_next = S_TEN;
            end
            S_TEN:
            begin
                inst_next  = prod_w[RECIP_SHIFT +: SPEED_W];
                state_next = S_STORE;
            end
            S_STORE:
            begin
                ring_we  = 1'b1;
                ptr_next = (ptr_reg == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
                if (fill_reg < FILL_W'(AVG_DEPTH))
                    fill_next = fill_reg + FILL_W'(1);
                idx_next   = '0;
                sum_next   = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'(speed_ring[idx_reg]);
                idx_next = idx_reg + PTR_W'(1);
                if (FILL_W'(idx_reg) + FILL_W'(1) == fill_reg)
                    state_next = S_AVG_GO;
            end
            S_AVG_GO:
                state_next = S_AVG_WAIT;
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[SPEED_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || speed_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_speed_next = avg_reg;
                    out_min_next   = min_reg;
                    out_max_next   = max_reg;
                    out_log_next   = log_w;
                    if (log_w)
                    begin
                        last_speed_next = avg_reg;
                        last_time_next  = now_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            floor_reg      <= FLOOR_RST;
            span_reg       <= SPAN_RST;
            offset_reg     <= OFFSET_RST;
            gap_reg        <= GAP_RST;
            min_reg        <= MIN_RST;
            max_reg        <= MAX_RST;
            ptr_reg        <= '0;
            fill_reg       <= '0;
            idx_reg        <= '0;
            last_speed_reg <= '0;
            last_time_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            floor_reg      <= floor_next;
            span_reg       <= span_next;
            offset_reg     <= offset_next;
            gap_reg        <= gap_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            ptr_reg        <= ptr_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            last_speed_reg <= last_speed_next;
            last_time_reg  <= last_time_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        now_reg       <= now_next;
        numer_reg     <= numer_next;
        frac_reg      <= frac_next;
        lin_reg       <= lin_next;
        inst_reg      <= inst_next;
        sum_reg       <= sum_next;
        avg_reg       <= avg_next;
        out_speed_reg <= out_speed_next;
        out_min_reg   <= out_min_next;
        out_max_reg   <= out_max_next;
        out_log_reg   <= out_log_next;
        if (ring_we)
            speed_ring[ptr_reg] <= inst_reg;
    end

    assign speed_out.valid             = out_valid_reg;
    assign speed_out.wind_speed_tenths = out_speed_reg;
    assign speed_out.sample_min        = out_min_reg;
    assign speed_out.sample_max        = out_max_reg;
    assign speed_out.log_now           = out_log_reg;

    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.ready |-> !div_rsp.busy)
        else $error("request accepted while divider busy");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_FRAC_WAIT || state_reg == S_AVG_WAIT))
        else $error("divider result outside a wait state");

    a_sum_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> (fill_reg != '0 && FILL_W'(idx_reg) < fill_reg))
        else $error("ring sum reads past filled entries");

    a_log_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_log_reg) |-> (out_speed_reg == last_speed_reg))
        else $error("logged speed differs from reported speed");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |=> (fill_reg != '0 && fill_reg <= FILL_W'(AVG_DEPTH)))
        else $error("fill count out of range after store");

endmodule

// ===== dv/tb.sv =====
// Testbench for current_loop_wind_speed_averager_top: scaled, averaged speed and log flag.
// Predicts each request in-line and checks results in order; random idling on both channels.
// Depends on clwsa_pkg and the clwsa_in_if, clwsa_out_if and clwsa_cfg_if interfaces.
module tb;
    import clwsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int REPORT_LIMIT   = 10;
    localparam int PERCENT        = 100;
    localparam int SPEED_SAT      = 2047;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_GAP + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic                log_flag;
    } speed_result_t;

    logic clk;
    logic rst_n;

    clwsa_in_if  sample_in();
    clwsa_out_if speed_out();
    clwsa_cfg_if cfg();

    current_loop_wind_speed_averager_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .speed_out (speed_out),
        .cfg       (cfg)
    );

    logic [SAMPLE_W-1:0] floor_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [GAP_W-1:0]    gap_reg;

    logic [SAMPLE_W-1:0] lo_seen;
    logic [SAMPLE_W-1:0] hi_seen;
    logic [SPEED_W-1:0]  speed_ring [AVG_DEPTH];
    int                  ring_slot;
    int                  ring_fill;
    logic [SPEED_W-1:0]  logged_speed;
    logic [TIME_W-1:0]   logged_time;

    speed_result_t speed_expected_q[$];
    int            mismatches;
    int            idle_cycles;
    bit            calm;
    logic [TIME_W-1:0] wall_clock;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic speed_result_t predict_speed(input logic [SAMPLE_W-1:0] s,
                                                    input logic [TIME_W-1:0] now);
        speed_result_t r;
        int unsigned range;
        int unsigned frac;
        int unsigned inst;
        int unsigned total;
        logic [TIME_W-1:0] elapsed;
        if (s > hi_seen)
            hi_seen = s;
        if (s < lo_seen)
            lo_seen = s;
        if (s < floor_reg)
            inst = 0;
        else
        begin
            range = 32'(hi_seen) - 32'(lo_seen);
            frac  = (range == 0) ? 0 : ((32'(s) - 32'(lo_seen)) * PERCENT) / range;
            inst  = (frac * 32'(span_reg) + 32'(offset_reg)) / 10;
            if (inst > SPEED_SAT)
                inst = SPEED_SAT;
        end
        speed_ring[ring_slot] = inst[SPEED_W-1:0];
        ring_slot = (ring_slot + 1 >= AVG_DEPTH) ? 0 : ring_slot + 1;
        if (ring_fill < AVG_DEPTH)
            ring_fill++;
        total = 0;
        for (int i = 0; i < ring_fill; i++)
            total += 32'(speed_ring[i]);
        r.speed    = SPEED_W'(total / ring_fill);
        r.lo       = lo_seen;
        r.hi       = hi_seen;
        r.log_flag = 1'b0;
        elapsed    = now - logged_time;
        if (r.speed != logged_speed && elapsed > TIME_W'(gap_reg))
        begin
            r.log_flag   = 1'b1;
            logged_speed = r.speed;
            logged_time  = now;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        speed_result_t got;
        speed_result_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (speed_out.valid && speed_out.ready)
            begin
                idle_cycles = 0;
                got.speed    = speed_out.wind_speed_tenths;
                got.lo       = speed_out.sample_min;
                got.hi       = speed_out.sample_max;
                got.log_flag = speed_out.log_now;
                if (speed_expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: speed %0d min %0d max %0d log %0b",
                                 got.speed, got.lo, got.hi, got.log_flag);
                end
                else
                begin
                    want = speed_expected_q.pop_front();
                    if (got.speed !== want.speed || got.lo !== want.lo ||
                        got.hi !== want.hi || got.log_flag !== want.log_flag)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch at %0t: speed %0d/%0d min %0d/%0d max %0d/%0d log %0b/%0b (expected/actual)",
                                     $realtime, want.speed, got.speed, want.lo, got.lo,
                                     want.hi, got.hi, want.log_flag, got.log_flag);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                idle_cycles = 0;
                case (cfg.index)
                    CFG_FLOOR:  floor_reg  = cfg.data[SAMPLE_W-1:0];
                    CFG_SPAN:   span_reg   = cfg.data[SPAN_W-1:0];
                    CFG_OFFSET: offset_reg = cfg.data[OFFSET_W-1:0];
                    CFG_GAP:    gap_reg    = cfg.data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (sample_in.valid && sample_in.ready)
            begin
                idle_cycles = 0;
                speed_expected_q.push_back(predict_speed(sample_in.adc_sample,
                                                         sample_in.now_seconds));
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        speed_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                speed_out.ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            speed_out.ready = 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            sample_in.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        sample_in.adc_sample  = s;
        sample_in.now_seconds = t;
        sample_in.valid       = 1'b1;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg.index = idx;
        cfg.data  = value;
        cfg.valid = 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic wait_for_results();
        sample_in.valid = 1'b0;
        while (speed_expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_settings(input logic [SAMPLE_W-1:0] flr, input logic [SPAN_W-1:0] span,
                                  input logic [OFFSET_W-1:0] ofs, input logic [GAP_W-1:0] gap);
        wait_for_results();
        write_register(CFG_FLOOR,  CFG_DATA_W'({$urandom(), flr}));
        write_register(CFG_SPAN,   CFG_DATA_W'({$urandom(), span}));
        write_register(CFG_OFFSET, CFG_DATA_W'({$urandom(), ofs}));
        write_register(CFG_GAP,    gap);
    endtask

    task automatic test_reset_defaults();
        send_sample(12'd819, 32'd0);
        send_sample(12'd818, 32'd600);
        send_sample(12'hFFF, 32'd1199);
        send_sample(12'hFFF, 32'd1200);
        send_sample(12'hAAA, 32'd1900);
        send_sample(12'h000, 32'd2600);
        send_sample(12'h555, 32'hFFFF_FF00);
        send_sample(12'd2048, 32'h0000_0100);
        send_sample(12'hFFF, 32'hFFFF_FFFF);
        send_sample(12'd1, 32'h5555_5555);
        send_sample(12'd2048, 32'hAAAA_AAAA);
    endtask

    task automatic test_register_extremes();
        write_settings('0, '1, '1, '0);
        send_sample(12'hFFF, 32'h0000_0001);
        send_sample(12'h000, 32'h0000_0002);
        send_sample(12'd2048, 32'h0000_0002);
        send_sample(12'hFFF, 32'h0000_0003);
        write_settings('1, '0, '0, '1);
        send_sample(12'd4094, 32'h8000_0000);
        send_sample(12'hFFF, 32'h8001_0000);
        send_sample(12'hFFF, 32'h0000_0000);
        write_settings(12'd1, 7'd1, 10'd1, 16'd1);
        send_sample(12'd1, 32'h0000_0010);
        send_sample(12'd3000, 32'h0000_0020);
    endtask

    task automatic test_unused_index();
        wait_for_results();
        write_register(CFG_FIRST_UNUSED, '1);
        write_register(CFG_LAST_UNUSED, '0);
        write_register(CFG_LAST_UNUSED, '1);
        send_sample(12'd1500, 32'h0001_0000);
        send_sample(12'd3500, 32'h0002_0000);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        logic [SAMPLE_W-1:0] s;
        logic [GAP_W-1:0]    gap;
        int                  near;
        for (int p = 0; p < phases; p++)
        begin
            gap = ($urandom_range(0, 3) == 0) ? GAP_W'($urandom()) : GAP_W'($urandom_range(0, 900));
            write_settings(($urandom_range(0, 1) == 0) ? SAMPLE_W'($urandom_range(0, 1200))
                                                       : SAMPLE_W'($urandom()),
                           ($urandom_range(0, 3) == 0) ? SPAN_W'($urandom())
                                                       : SPAN_W'($urandom_range(1, 100)),
                           ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom())
                                                       : OFFSET_W'($urandom_range(0, 200)),
                           gap);
            if ($urandom_range(0, 2) == 0)
                write_register(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                               CFG_DATA_W'($urandom()));
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    near = int'(floor_reg) + int'($urandom_range(0, 6)) - 3;
                    s = (near < 0) ? '0 : (near > 4095) ? '1 : SAMPLE_W'(near);
                end
                else
                    s = SAMPLE_W'($urandom());
                if ($urandom_range(0, 7) == 0)
                    wall_clock = $urandom();
                else
                    wall_clock += $urandom_range(0, 700);
                send_sample(s, wall_clock);
            end
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        sample_in.valid       = 1'b0;
        sample_in.adc_sample  = '0;
        sample_in.now_seconds = '0;
        cfg.valid             = 1'b0;
        cfg.index             = '0;
        cfg.data              = '0;
        calm                  = 1'b0;
        mismatches            = 0;
        idle_cycles           = 0;
        wall_clock            = '0;
        floor_reg             = FLOOR_RST;
        span_reg              = SPAN_RST;
        offset_reg            = OFFSET_RST;
        gap_reg               = GAP_RST;
        lo_seen               = MIN_RST;
        hi_seen               = MAX_RST;
        ring_slot             = 0;
        ring_fill             = 0;
        logged_speed          = '0;
        logged_time           = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_unused_index();
        test_random_phases(10, 55);
        calm = 1'b1;
        test_random_phases(2, 50);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
